// ----- sv/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the timer scheduler RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/mtes_pkg.sv -----
// ---------------------------------------------------------------------------
// mtes_pkg
// Types and constants shared by the timer scheduler front, back and top.
// ---------------------------------------------------------------------------
package mtes_pkg;

   localparam int DEF_NUM_TIMERS = 16;
   localparam int DEF_TIME_BITS  = 32;
   localparam int ID_W           = 4;
   localparam int PERIOD_W       = 32;
   localparam int NOW_W          = 32;
   localparam int MAX_RESULTS    = 16;
   localparam int CNT_W          = 5;
   localparam int REQ_DATA_W     = 40;
   localparam int RSP_DATA_W     = 40;

   typedef enum logic [1:0] {
      CMD_START = 2'd0,
      CMD_STOP  = 2'd1,
      CMD_TICK  = 2'd2,
      CMD_QUERY = 2'd3
   } mtes_op_type;

   // classified command as it sits in the queue
   typedef struct packed {
      mtes_op_type         op;
      logic                id_ok;
      logic [ID_W-1:0]     id;
      logic [PERIOD_W-1:0] period;
      logic                single;
   } mtes_cmd_type;

   typedef struct packed {
      logic [ID_W-1:0]  id;
      logic             fired;
      logic             running;
      logic [NOW_W-1:0] now;
      logic             last;
   } mtes_rsp_type;

endpackage

// ----- sv/multi_timer_expiry_scheduler_top.sv -----
// ---------------------------------------------------------------------------
// multi_timer_expiry_scheduler_top
// Bank of virtual millisecond timers: start, stop, query and tick commands.
//
//  channel  dir  handshake            payload
//  req      in   req_tvalid/tready    tuser command, tdata id/period/single
//  rsp      out  rsp_tvalid/tready    tuser fired, tdata id/running/now, tlast
//
// Start, stop and query are executed by the back end from its idle state. A
// tick walks the rank list once for timers due at the old time and once for
// those due at the new time, one entry a cycle unless a result stalls.
// A two-entry command queue lets commands arrive while a tick is walked.
// Reset is synchronous and clears all timers and the time. A stalled result
// holds the walk only when a further result has to leave.
// ---------------------------------------------------------------------------
module multi_timer_expiry_scheduler_top #(
   parameter int NUM_TIMERS = mtes_pkg::DEF_NUM_TIMERS,
   parameter int TIME_BITS  = mtes_pkg::DEF_TIME_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [mtes_pkg::REQ_DATA_W-1:0]   req_tdata,  // timer_id, period_ms, single_shot
   input  logic [1:0]                        req_tuser,  // command
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [mtes_pkg::RSP_DATA_W-1:0]   rsp_tdata,  // fired_timer, running, now_ms
   output logic                              rsp_tuser,  // fired
   output logic                              rsp_tlast
);
   import mtes_pkg::*;

   mtes_cmd_type q_item;
   logic         q_valid, q_pop;
   mtes_rsp_type rsp_item;

   mtes_front #(.NUM_TIMERS(NUM_TIMERS), .TIME_BITS(TIME_BITS)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_op     (mtes_op_type'(req_tuser)),
      .req_id     (req_tdata[3:0]),
      .req_period (req_tdata[35:4]),
      .req_single (req_tdata[36]),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop)
   );

   mtes_back #(.NUM_TIMERS(NUM_TIMERS), .TIME_BITS(TIME_BITS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_pop     (q_pop),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_item  (rsp_item)
   );

   assign rsp_tdata = {3'b000, rsp_item.now, rsp_item.running, rsp_item.id};
   assign rsp_tuser = rsp_item.fired;
   assign rsp_tlast = rsp_item.last;

endmodule

// ----- sv/mtes_front.sv -----
// ---------------------------------------------------------------------------
// mtes_front
// Accepts commands, checks the timer number, fixes the period and queues
// the classified command for the back end (two entries).
// ---------------------------------------------------------------------------
module mtes_front #(
   parameter int NUM_TIMERS = mtes_pkg::DEF_NUM_TIMERS,
   parameter int TIME_BITS  = mtes_pkg::DEF_TIME_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  mtes_pkg::mtes_op_type req_op,
   input  logic [3:0]            req_id,
   input  logic [31:0]           req_period,
   input  logic                  req_single,
   output logic                  q_valid,
   output mtes_pkg::mtes_cmd_type q_item,
   input  logic                  q_pop
);
   import mtes_pkg::*;

   localparam logic [PERIOD_W-1:0] PMASK =
      (TIME_BITS >= PERIOD_W) ? '1 : PERIOD_W'((64'd1 << TIME_BITS) - 64'd1);

   mtes_cmd_type buf_ff [2];
   logic         wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0]   cnt_ff, cnt_in;
   mtes_cmd_type cls;
   logic [PERIOD_W-1:0] pm;
   logic         push;

   always_comb begin
      pm           = req_period & PMASK;
      cls.op       = req_op;
      cls.id       = req_id;
      cls.id_ok    = ({3'b000, req_id} < 7'(NUM_TIMERS));
      cls.single   = req_single;
      // periodic zero period would never advance; force one
      cls.period   = (!req_single && pm == '0) ? PERIOD_W'(1) : pm;
   end

   assign req_tready = (cnt_ff != 2'd2);
   assign push       = req_tvalid && req_tready;
   assign q_valid    = (cnt_ff != 2'd0);
   assign q_item     = buf_ff[rd_ff];

   always_comb begin
      wr_in  = push ? ~wr_ff : wr_ff;
      rd_in  = q_pop ? ~rd_ff : rd_ff;
      cnt_in = cnt_ff + 2'(push) - 2'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         buf_ff[wr_ff] <= cls;
      end
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

// ----- sv/mtes_back.sv -----
// ---------------------------------------------------------------------------
// mtes_back
// Executes queued commands against the timer bank. Keeps the arming order
// as a rank list and walks it twice per tick: first for timers due at the
// old time, then for timers due at the new time.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module mtes_back #(
   parameter int NUM_TIMERS = mtes_pkg::DEF_NUM_TIMERS,
   parameter int TIME_BITS  = mtes_pkg::DEF_TIME_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_valid,
   input  mtes_pkg::mtes_cmd_type q_item,
   output logic                   q_pop,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output mtes_pkg::mtes_rsp_type rsp_item
);
   import mtes_pkg::*;

   localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
   localparam int CW = $clog2(NUM_TIMERS + 1);
   localparam int TB = TIME_BITS;

   typedef enum logic [1:0] {S_IDLE, S_SCAN_A, S_SCAN_B} state_type;

   state_type          state_ff, state_in;
   logic [NUM_TIMERS-1:0] armed_ff, oneshot_ff;
   logic [TB-1:0]      period_ff [NUM_TIMERS];
   logic [TB-1:0]      exp_ff    [NUM_TIMERS];
   logic [IW-1:0]      ord_ff    [NUM_TIMERS];
   logic [IW-1:0]      ord_in    [NUM_TIMERS];
   logic [TB-1:0]      now_ff, now_in, old_ff, old_in;
   logic [CW-1:0]      n_ff, n_in, r_ff, r_in, lim_ff, lim_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               pv_ff, pv_in;
   logic [IW-1:0]      pid_ff, pid_in;
   logic               prun_ff, prun_in;
   logic               ov_ff, ov_in;
   mtes_rsp_type       out_ff, out_in;

   // list and timer write controls
   logic               rm_en, app_en;
   logic [IW-1:0]      rm_pos, app_id;
   logic [CW-1:0]      app_pos;
   logic               tw_en, tw_armed, tw_exp_en, tw_cfg_en;
   logic [IW-1:0]      tw_idx;
   logic [TB-1:0]      tw_exp;

   logic               out_free;
   logic [IW-1:0]      idx, mpos, sid;
   logic               due, report, need;

   assign out_free  = !ov_ff || rsp_ready;
   assign rsp_valid = ov_ff;
   assign rsp_item  = out_ff;
   assign idx       = IW'(q_item.id);
   assign sid       = ord_ff[r_ff[IW-1:0]];

   always_comb begin
      mpos = '0;
      for (int i = 0; i < NUM_TIMERS; i++) begin
         if (ord_ff[i] == idx && CW'(i) < n_ff) begin
            mpos = IW'(i);
         end
      end
   end

   always_comb begin
      state_in  = state_ff;
      now_in    = now_ff;
      old_in    = old_ff;
      r_in      = r_ff;
      lim_in    = lim_ff;
      cnt_in    = cnt_ff;
      pv_in     = pv_ff;
      pid_in    = pid_ff;
      prun_in   = prun_ff;
      ov_in     = ov_ff && !rsp_ready;
      out_in    = out_ff;
      q_pop     = 1'b0;
      rm_en     = 1'b0;
      rm_pos    = '0;
      app_en    = 1'b0;
      app_id    = '0;
      tw_en     = 1'b0;
      tw_idx    = '0;
      tw_armed  = 1'b0;
      tw_exp_en = 1'b0;
      tw_exp    = '0;
      tw_cfg_en = 1'b0;
      due       = 1'b0;
      report    = 1'b0;
      need      = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               if (q_item.op == CMD_TICK) begin
                  q_pop    = 1'b1;
                  now_in   = now_ff + TB'(1);
                  old_in   = now_ff;
                  r_in     = '0;
                  lim_in   = n_ff;
                  cnt_in   = '0;
                  pv_in    = 1'b0;
                  state_in = S_SCAN_A;
               end else if (out_free) begin
                  q_pop          = 1'b1;
                  ov_in          = 1'b1;
                  out_in.id      = q_item.id;
                  out_in.fired   = 1'b0;
                  out_in.running = 1'b0;
                  out_in.now     = NOW_W'(now_ff);
                  out_in.last    = 1'b1;
                  tw_idx         = idx;
                  case (q_item.op)
                     CMD_START: begin
                        if (q_item.id_ok) begin
                           rm_en          = armed_ff[idx];
                           rm_pos         = mpos;
                           app_en         = 1'b1;
                           app_id         = idx;
                           tw_en          = 1'b1;
                           tw_armed       = 1'b1;
                           tw_exp_en      = 1'b1;
                           tw_exp         = now_ff + TB'(q_item.period);
                           tw_cfg_en      = 1'b1;
                           out_in.running = 1'b1;
                        end
                     end
                     CMD_STOP: begin
                        if (q_item.id_ok && armed_ff[idx]) begin
                           rm_en  = 1'b1;
                           rm_pos = mpos;
                           tw_en  = 1'b1;
                        end
                     end
                     CMD_QUERY: begin
                        out_in.running = q_item.id_ok && armed_ff[idx];
                     end
                     default: begin
                     end
                  endcase
               end
            end
         end
         S_SCAN_A, S_SCAN_B: begin
            if (r_ff == lim_ff) begin
               if (state_ff == S_SCAN_A) begin
                  r_in     = '0;
                  state_in = S_SCAN_B;
               end else if (out_free) begin
                  ov_in          = 1'b1;
                  out_in.id      = pv_ff ? ID_W'(pid_ff) : '0;
                  out_in.fired   = pv_ff;
                  out_in.running = pv_ff && prun_ff;
                  out_in.now     = NOW_W'(now_ff);
                  out_in.last    = 1'b1;
                  state_in       = S_IDLE;
               end
            end else begin
               due    = exp_ff[sid] == ((state_ff == S_SCAN_A) ? old_ff : now_ff);
               report = cnt_ff < CNT_W'(MAX_RESULTS);
               need   = report && pv_ff;
               if (!due) begin
                  r_in = r_ff + CW'(1);
               end else if (!need || out_free) begin
                  if (need) begin
                     ov_in          = 1'b1;
                     out_in.id      = ID_W'(pid_ff);
                     out_in.fired   = 1'b1;
                     out_in.running = prun_ff;
                     out_in.now     = NOW_W'(now_ff);
                     out_in.last    = 1'b0;
                  end
                  if (report) begin
                     pv_in   = 1'b1;
                     pid_in  = sid;
                     prun_in = !oneshot_ff[sid];
                     cnt_in  = cnt_ff + CNT_W'(1);
                  end
                  // take out of the walk; periodic ones go to the back of the order
                  rm_en     = 1'b1;
                  rm_pos    = r_ff[IW-1:0];
                  lim_in    = lim_ff - CW'(1);
                  tw_en     = 1'b1;
                  tw_idx    = sid;
                  tw_armed  = !oneshot_ff[sid];
                  app_en    = !oneshot_ff[sid];
                  app_id    = sid;
                  tw_exp_en = !oneshot_ff[sid];
                  tw_exp    = now_ff + period_ff[sid];
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      app_pos = rm_en ? n_ff - CW'(1) : n_ff;
      n_in    = n_ff - CW'(rm_en) + CW'(app_en);
      for (int i = 0; i < NUM_TIMERS; i++) begin
         ord_in[i] = ord_ff[i];
         if (rm_en && IW'(i) >= rm_pos && i < NUM_TIMERS - 1) begin
            ord_in[i] = ord_ff[(i < NUM_TIMERS - 1) ? i + 1 : i];
         end
         if (app_en && app_pos[IW-1:0] == IW'(i)) begin
            ord_in[i] = app_id;
         end
      end
   end

   always_ff @(posedge clock) begin
      ord_ff  <= ord_in;
      out_ff  <= out_in;
      old_ff  <= old_in;
      pid_ff  <= pid_in;
      prun_ff <= prun_in;
      if (tw_exp_en) begin
         exp_ff[tw_idx] <= tw_exp;
      end
      if (tw_cfg_en) begin
         period_ff[tw_idx] <= TB'(q_item.period);
      end
      if (reset) begin
         state_ff   <= S_IDLE;
         armed_ff   <= '0;
         oneshot_ff <= '0;
         now_ff     <= '0;
         n_ff       <= '0;
         r_ff       <= '0;
         lim_ff     <= '0;
         cnt_ff     <= '0;
         pv_ff      <= 1'b0;
         ov_ff      <= 1'b0;
      end else begin
         state_ff <= state_in;
         now_ff   <= now_in;
         n_ff     <= n_in;
         r_ff     <= r_in;
         lim_ff   <= lim_in;
         cnt_ff   <= cnt_in;
         pv_ff    <= pv_in;
         ov_ff    <= ov_in;
         if (tw_en) begin
            armed_ff[tw_idx] <= tw_armed;
         end
         if (tw_cfg_en) begin
            oneshot_ff[tw_idx] <= q_item.single;
         end
      end
   end

   `ASSERT_CLK(a_armed_count, clock, reset, $countones(armed_ff) == int'(n_ff), "armed count mismatch")
   `ASSERT_CLK(a_walk_bounds, clock, reset, (state_ff == S_IDLE) || (r_ff <= lim_ff && lim_ff <= n_ff), "walk out of bounds")
   `ASSERT_CLK(a_fire_cap, clock, reset, cnt_ff <= CNT_W'(MAX_RESULTS), "fire count overflow")
   `ASSERT_NEXT(a_tick_start, clock, reset, state_ff == S_IDLE && q_pop && q_item.op == CMD_TICK, state_ff == S_SCAN_A, "tick did not start walk")

endmodule
